/* rtl/core/tracker_event_packet_parser_core_defines.svh */
// Assertion macros shared by the tracker event packet parser modules.
`ifndef TRACKER_EVENT_PACKET_PARSER_CORE_DEFINES_SVH
`define TRACKER_EVENT_PACKET_PARSER_CORE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define TEP_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TEP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

/* rtl/core/tep_pkg.sv */
// Package with record types, codes and helpers for the tracker event packet parser.
package tep_pkg;
    localparam int HdrLen = 17;
    localparam int EvtLen = 12;
    localparam int QueueDepth = 4;
    localparam logic [7:0] EventLimitReset = 8'd170;
    localparam logic [7:0] HitLimitReset = 8'd192;

    localparam logic [1:0] CFG_EVENT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_HIT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;

    localparam logic [2:0] K_HEAD = 3'd0;
    localparam logic [2:0] K_EVT = 3'd1;
    localparam logic [2:0] K_HIT = 3'd2;
    localparam logic [2:0] K_OK = 3'd3;
    localparam logic [2:0] K_ERR = 3'd4;

    localparam logic [1:0] E_SHORT = 2'd0;
    localparam logic [1:0] E_EVENTS = 2'd1;
    localparam logic [1:0] E_HITS = 2'd2;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [47:0] time_value;
        logic [31:0] ident;
        logic [55:0] info;
        logic [15:0] run_number;
        logic [7:0]  layer;
        logic [2:0]  module_res;
        logic [2:0]  row;
        logic [4:0]  channel;
        logic [10:0] adc_value;
        logic [1:0]  asic_code;
        logic [1:0]  error_code;
    } rec_t;

    // Up to two records caused by one byte.
    typedef struct packed {
        logic n0;
        logic n1;
        rec_t r0;
        rec_t r1;
    } pair_t;

    localparam int RecW = $bits(rec_t);
    localparam int PairW = $bits(pair_t);

    function automatic rec_t rec_blank(input logic [2:0] kind);
        rec_t r;
        r = '0;
        r.record_kind = kind;
        return r;
    endfunction

    function automatic logic [15:0] f2(input logic [7:0] a, input logic [7:0] b,
                                       input logic be);
        return be ? {a, b} : {b, a};
    endfunction

    function automatic logic [31:0] f4(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d,
                                       input logic be);
        return be ? {a, b, c, d} : {d, c, b, a};
    endfunction
endpackage

/* rtl/core/tep_front.sv */
// Front part: byte parser that classifies bytes and builds up to two records per byte.
module tep_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    output tep_pkg::pair_t    out_pair
);
    import tep_pkg::*;
    `include "tracker_event_packet_parser_core_defines.svh"

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_EVT = 2'd1;
    localparam logic [1:0] PH_HIT = 2'd2;

    logic [7:0] event_limit_reg;
    logic [7:0] hit_limit_reg;
    logic       big_endian_reg;

    logic [1:0] phase_reg, phase_next;
    logic [4:0] offset_reg, offset_next;
    logic [7:0] hdr_reg [HdrLen+2];
    logic [7:0] evt_reg [EvtLen];
    logic [8:0] events_reg, events_next;
    logic [7:0] hits_left_reg, hits_left_next;
    logic [15:0] hit_total_reg, hit_total_next;
    logic [15:0] partial_reg;
    logic       discard_reg, discard_next;
    pair_t      pair_next;
    logic       emit;

    // Combined views of the stored bytes and the byte in flight.
    logic [7:0] ver;
    logic [7:0] h16_now;
    logic [7:0] e0, e1, e2, e3, e4, e5, e6, e7, e8, e9, e10, e11;
    rec_t       rec_a, rec_b;
    logic       a_v, b_v;
    logic       ver4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_limit_reg <= EventLimitReset;
            hit_limit_reg <= HitLimitReset;
            big_endian_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EVENT_LIMIT: event_limit_reg <= cfg_data;
                CFG_HIT_LIMIT:   hit_limit_reg <= cfg_data;
                CFG_BIG_ENDIAN:  big_endian_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign h16_now = (offset_reg == 5'd16) ? data_byte : hdr_reg[16];
    assign ver = hdr_reg[16];
    assign ver4 = ver >= 8'd4;
    assign e0 = evt_reg[0];  assign e1 = evt_reg[1];  assign e2 = evt_reg[2];
    assign e3 = evt_reg[3];  assign e4 = evt_reg[4];  assign e5 = evt_reg[5];
    assign e6 = evt_reg[6];  assign e7 = evt_reg[7];  assign e8 = evt_reg[8];
    assign e9 = evt_reg[9];  assign e10 = evt_reg[10];
    assign e11 = data_byte;

    always_comb
    begin
        logic [4:0] off1;
        logic       need2;
        logic [7:0] r0b, r1b;
        logic [8:0] ev1;
        logic [7:0] hl;
        phase_next = phase_reg;
        offset_next = offset_reg;
        events_next = events_reg;
        hits_left_next = hits_left_reg;
        hit_total_next = hit_total_reg;
        discard_next = discard_reg;
        a_v = 1'b0;
        b_v = 1'b0;
        rec_a = '0;
        rec_b = '0;
        off1 = offset_reg + 5'd1;
        need2 = h16_now >= 8'd5;
        r0b = (offset_reg == 5'd17) ? data_byte : hdr_reg[17];
        r1b = data_byte;
        ev1 = events_reg + 9'd1;
        hl = hits_left_reg;
        if (discard_reg)
        begin
            if (last_byte)
            begin
                discard_next = 1'b0;
                phase_next = PH_HEAD;
                offset_next = '0;
                events_next = '0;
                hits_left_next = '0;
                hit_total_next = '0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    offset_next = off1;
                    if (off1 <= 5'(HdrLen) || (need2 && off1 < 5'(HdrLen + 2)))
                    begin
                        if (last_byte)
                        begin
                            a_v = 1'b1;
                            rec_a = rec_blank(K_ERR);
                            rec_a.error_code = E_SHORT;
                            offset_next = '0;
                        end
                    end
                    else
                    begin
                        a_v = 1'b1;
                        rec_a = rec_blank(K_HEAD);
                        rec_a.time_value = {f2(hdr_reg[14], hdr_reg[15], big_endian_reg),
                            f4(hdr_reg[10], hdr_reg[11], hdr_reg[12], hdr_reg[13],
                               big_endian_reg)};
                        rec_a.ident = {f2(hdr_reg[0], hdr_reg[1], big_endian_reg),
                            f2(hdr_reg[2], hdr_reg[3], big_endian_reg)};
                        rec_a.info = {hdr_reg[4], hdr_reg[5],
                            f2(hdr_reg[6], hdr_reg[7], big_endian_reg),
                            f2(hdr_reg[8], hdr_reg[9], big_endian_reg), ver};
                        rec_a.run_number = need2 ? f2(r0b, r1b, big_endian_reg)
                                                 : {8'd0, r0b};
                        phase_next = PH_EVT;
                        offset_next = '0;
                        events_next = '0;
                        hit_total_next = '0;
                        // No events seen yet, so only the end check applies here.
                        if (last_byte)
                        begin
                            b_v = 1'b1;
                            rec_b = rec_blank(ver4 ? K_OK : K_ERR);
                            rec_b.error_code = E_SHORT;
                            phase_next = PH_HEAD;
                        end
                    end
                end
                PH_EVT:
                begin
                    if (offset_reg == 5'd0 && last_byte && data_byte == 8'hff && ver4)
                    begin
                        a_v = 1'b1;
                        rec_a = rec_blank(K_OK);
                        rec_a.info = {40'd0, hit_total_reg};
                        phase_next = PH_HEAD;
                        events_next = '0;
                        hit_total_next = '0;
                    end
                    else if (off1 < 5'(EvtLen))
                    begin
                        offset_next = off1;
                        if (last_byte)
                        begin
                            a_v = 1'b1;
                            rec_a = rec_blank(K_ERR);
                            rec_a.error_code = E_SHORT;
                            phase_next = PH_HEAD;
                            offset_next = '0;
                            events_next = '0;
                            hit_total_next = '0;
                        end
                    end
                    else
                    begin
                        offset_next = '0;
                        if (e0 > hit_limit_reg)
                        begin
                            a_v = 1'b1;
                            rec_a = rec_blank(K_ERR);
                            rec_a.error_code = E_HITS;
                            if (last_byte)
                            begin
                                phase_next = PH_HEAD;
                                events_next = '0;
                                hit_total_next = '0;
                            end
                            else
                            begin
                                discard_next = 1'b1;
                            end
                        end
                        else
                        begin
                            a_v = 1'b1;
                            rec_a = rec_blank(K_EVT);
                            rec_a.time_value = {f2(e10, e11, big_endian_reg),
                                f4(e6, e7, e8, e9, big_endian_reg)};
                            rec_a.ident = f4(e2, e3, e4, e5, big_endian_reg);
                            rec_a.info = {40'd0, e0, e1};
                            if (e0 == 8'd0)
                            begin
                                events_next = ev1;
                                if (ev1 > {1'b0, event_limit_reg})
                                begin
                                    b_v = 1'b1;
                                    rec_b = rec_blank(K_ERR);
                                    rec_b.error_code = E_EVENTS;
                                    if (last_byte)
                                    begin
                                        phase_next = PH_HEAD;
                                        events_next = '0;
                                        hit_total_next = '0;
                                    end
                                    else
                                    begin
                                        discard_next = 1'b1;
                                    end
                                end
                                else if (last_byte)
                                begin
                                    b_v = 1'b1;
                                    rec_b = rec_blank(ver4 ? K_OK : K_ERR);
                                    rec_b.info = ver4 ? {40'd0, hit_total_reg} : '0;
                                    rec_b.error_code = E_SHORT;
                                    phase_next = PH_HEAD;
                                    events_next = '0;
                                    hit_total_next = '0;
                                end
                            end
                            else
                            begin
                                hits_left_next = e0;
                                phase_next = PH_HIT;
                                if (last_byte)
                                begin
                                    b_v = 1'b1;
                                    rec_b = rec_blank(K_ERR);
                                    rec_b.error_code = E_SHORT;
                                    phase_next = PH_HEAD;
                                    events_next = '0;
                                    hits_left_next = '0;
                                    hit_total_next = '0;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    if (offset_reg < 5'd2)
                    begin
                        offset_next = off1;
                        if (last_byte)
                        begin
                            a_v = 1'b1;
                            rec_a = rec_blank(K_ERR);
                            rec_a.error_code = E_SHORT;
                            phase_next = PH_HEAD;
                            offset_next = '0;
                            events_next = '0;
                            hits_left_next = '0;
                            hit_total_next = '0;
                        end
                    end
                    else
                    begin
                        a_v = 1'b1;
                        rec_a = rec_blank(K_HIT);
                        rec_a.layer = hdr_reg[4] + 8'd128;
                        rec_a.module_res = partial_reg[7:5];
                        rec_a.row = partial_reg[10:8];
                        rec_a.channel = partial_reg[4:0];
                        rec_a.adc_value = {data_byte[5:0], partial_reg[15:11]};
                        rec_a.asic_code = data_byte[7:6];
                        offset_next = '0;
                        hit_total_next = hit_total_reg + 16'd1;
                        if (hl > 8'd0)
                        begin
                            hl = hl - 8'd1;
                        end
                        hits_left_next = hl;
                        if (hl == 8'd0)
                        begin
                            events_next = ev1;
                            phase_next = PH_EVT;
                            if (ev1 > {1'b0, event_limit_reg})
                            begin
                                b_v = 1'b1;
                                rec_b = rec_blank(K_ERR);
                                rec_b.error_code = E_EVENTS;
                                if (last_byte)
                                begin
                                    phase_next = PH_HEAD;
                                    events_next = '0;
                                    hit_total_next = '0;
                                end
                                else
                                begin
                                    discard_next = 1'b1;
                                end
                            end
                            else if (last_byte)
                            begin
                                b_v = 1'b1;
                                rec_b = rec_blank(ver4 ? K_OK : K_ERR);
                                rec_b.info = ver4 ? {40'd0, hit_total_next} : '0;
                                rec_b.error_code = E_SHORT;
                                phase_next = PH_HEAD;
                                events_next = '0;
                                hit_total_next = '0;
                            end
                        end
                        else if (last_byte)
                        begin
                            b_v = 1'b1;
                            rec_b = rec_blank(K_ERR);
                            rec_b.error_code = E_SHORT;
                            phase_next = PH_HEAD;
                            events_next = '0;
                            hits_left_next = '0;
                            hit_total_next = '0;
                        end
                    end
                end
            endcase
        end
        // Accept records carry no error code; error records no total.
        if (rec_a.record_kind != K_ERR) rec_a.error_code = '0;
        if (rec_b.record_kind != K_ERR) rec_b.error_code = '0;
        if (rec_b.record_kind == K_ERR) rec_b.info = '0;
        pair_next.n0 = a_v;
        pair_next.n1 = b_v;
        pair_next.r0 = rec_a;
        pair_next.r1 = rec_b;
        emit = a_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            offset_reg <= '0;
            events_reg <= '0;
            hits_left_reg <= '0;
            hit_total_reg <= '0;
            discard_reg <= 1'b0;
            out_valid <= 1'b0;
            for (int i = 0; i < HdrLen + 2; i++) hdr_reg[i] <= '0;
            for (int i = 0; i < EvtLen; i++) evt_reg[i] <= '0;
        end
        else
        begin
            out_valid <= in_fire && emit;
            if (in_fire)
            begin
                phase_reg <= phase_next;
                offset_reg <= offset_next;
                events_reg <= events_next;
                hits_left_reg <= hits_left_next;
                hit_total_reg <= hit_total_next;
                discard_reg <= discard_next;
                if (!discard_reg && phase_reg == PH_HEAD && offset_reg < 5'(HdrLen + 2))
                begin
                    hdr_reg[offset_reg] <= data_byte;
                end
                if (!discard_reg && phase_reg == PH_EVT && offset_reg < 5'(EvtLen))
                begin
                    evt_reg[offset_reg[3:0]] <= data_byte;
                end
                if (!discard_reg && phase_reg == PH_HIT && offset_reg == 5'd0)
                begin
                    partial_reg <= {8'd0, data_byte};
                end
                if (!discard_reg && phase_reg == PH_HIT && offset_reg == 5'd1)
                begin
                    partial_reg <= {data_byte, partial_reg[7:0]};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_pair <= pair_next;
        end
    end

    `TEP_ASSERT_NEXT(a_emit_only_on_fire, clk, rst_n, !in_fire, !out_valid)
    `TEP_ASSERT_IMP(a_second_needs_first, clk, rst_n, out_valid && out_pair.n1, out_pair.n0)
    `TEP_ASSERT_IMP(a_offset_bound, clk, rst_n, 1'b1, offset_reg <= 5'(HdrLen + 1))
endmodule

/* rtl/core/tep_queue.sv */
// Short queue of record pairs between the parser and the output stage.
module tep_queue
#(
    parameter int Depth = tep_pkg::QueueDepth
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tep_pkg::pair_t push_data,
    input  logic           pop,
    output logic           not_empty,
    output logic [$clog2(Depth+1)-1:0] count,
    output tep_pkg::pair_t head
);
    import tep_pkg::*;
    `include "tracker_event_packet_parser_core_defines.svh"

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    pair_t mem_reg [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [$clog2(Depth+1)-1:0] cnt_reg;

    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;
    assign head = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    `TEP_ASSERT_IMP(a_no_overflow, clk, rst_n, push && !pop, cnt_reg != ($clog2(Depth+1))'(Depth))
    `TEP_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, cnt_reg != '0)
endmodule

/* rtl/core/tep_back.sv */
// Back part: drains record pairs one record per transfer onto the output stream.
module tep_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  tep_pkg::pair_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output tep_pkg::rec_t  m_rec
);
    import tep_pkg::*;

    logic second_reg;

    assign m_tvalid = q_valid;
    assign m_rec = second_reg ? q_head.r1 : q_head.r0;
    assign q_pop = q_valid && m_tready && (second_reg || !q_head.n1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else if (q_valid && m_tready)
        begin
            second_reg <= !second_reg && q_head.n1;
        end
    end
endmodule

/* rtl/core/tracker_event_packet_parser_core.sv */
// Top level of the tracker event packet parser.
// The parser takes one packet byte per transfer on the slave stream (tdata = data_byte,
// tlast = last_byte) and can take a byte in every cycle. The front parser forms a byte's
// records and registers them, a four-entry queue holds them, and the back stage sends one
// record per output transfer, so a byte that causes two records holds the output for two
// transfers. Input is taken while the queue has room for the byte in flight, so stalls on
// the output side reach the input only after the queue fills. Configuration writes must go
// in only while idle; the user is bound to this and the block itself does not enforce it.
module tracker_event_packet_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // record_kind, time_value, ident, info, run_number, layer, module_res, row,
    // channel, adc_value, asic_code, error_code, then zero fill to 192 bits
    output logic [191:0] m_tdata
);
    import tep_pkg::*;

    logic  in_fire, f_valid, q_ne, q_pop;
    pair_t f_pair, q_head;
    rec_t  rec;
    logic [$clog2(QueueDepth+1)-1:0] q_count;

    // Room for the queue contents plus one pair still in the front register.
    assign s_tready = q_count < ($clog2(QueueDepth+1))'(QueueDepth - 1);
    assign in_fire = s_tvalid && s_tready;

    tep_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_fire(in_fire), .data_byte(s_tdata),
        .last_byte(s_tlast), .out_valid(f_valid), .out_pair(f_pair)
    );

    tep_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_pair), .pop(q_pop),
        .not_empty(q_ne), .count(q_count), .head(q_head)
    );

    tep_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_head(q_head), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_rec(rec)
    );

    assign m_tdata = {(192 - RecW)'(0), rec.error_code, rec.asic_code, rec.adc_value,
        rec.channel, rec.row, rec.module_res, rec.layer, rec.run_number, rec.info,
        rec.ident, rec.time_value, rec.record_kind};
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the tracker event packet parser core.
`timescale 1ns / 1ps

module tb;
    import tep_pkg::*;

    // One packet byte as it travels on the input stream.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [7:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;

    tracker_event_packet_parser_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Bytes waiting to be sent, and records the parser still owes us.
    byte_t pending_bytes[$];
    rec_t  expected_records[$];
    int    mismatch_count;
    bit    calm_mode;
    bit    stall_hold;
    int    stall_cycles;
    bit    in_taken;

    // Shadow copy of the parser state and its registers.
    logic [7:0]  lim_events;
    logic [7:0]  lim_hits;
    logic        be_order;
    int          sh_phase;
    int          sh_offset;
    logic [7:0]  hdr_bytes[19];
    logic [7:0]  evt_bytes[12];
    int          events_count;
    int          hits_remaining;
    int          hits_sum;
    logic [15:0] hit_bytes;
    bit          dropping;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Assemble a field of n bytes at offset off, honoring the byte order.
    function automatic logic [63:0] field_of(input logic [7:0] buf_b[], input int off,
                                             input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            if (be_order)
                v = (v << 8) | buf_b[off + i];
            else
                v = v | (64'(buf_b[off + i]) << (8 * i));
        end
        return v;
    endfunction

    function automatic void rearm();
        sh_phase = 0;
        sh_offset = 0;
        events_count = 0;
        hits_remaining = 0;
        hits_sum = 0;
        hit_bytes = '0;
        dropping = 1'b0;
    endfunction

    function automatic void expect_record(input rec_t r);
        expected_records.insert(expected_records.size(), r);
    endfunction

    function automatic void push_error(input logic [1:0] code, input bit last);
        rec_t r;
        r = '0;
        r.record_kind = K_ERR;
        r.error_code = code;
        expect_record(r);
        if (last)
            rearm();
        else
            dropping = 1'b1;
    endfunction

    function automatic void push_accept();
        rec_t r;
        r = '0;
        r.record_kind = K_OK;
        r.info = 56'(hits_sum);
        expect_record(r);
        rearm();
    endfunction

    // Checks made whenever an event (or the run id) completes.
    function automatic void close_event(input bit last);
        if (events_count > lim_events)
            push_error(E_EVENTS, last);
        else if (last)
        begin
            if (hdr_bytes[16] >= 4)
                push_accept();
            else
                push_error(E_SHORT, 1'b1);
        end
    endfunction

    // Predict the records caused by one accepted byte.
    function automatic void predict_byte(input logic [7:0] b, input bit last);
        rec_t r;
        int need;
        int n;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] hb[];
        r = '0;
        if (dropping)
        begin
            if (last)
                rearm();
            return;
        end
        if (sh_phase == 0)
        begin
            if (sh_offset < 19)
                hdr_bytes[sh_offset] = b;
            sh_offset++;
            need = (hdr_bytes[16] >= 5) ? 19 : 18;
            if (sh_offset <= 17 || sh_offset < need)
            begin
                if (last)
                    push_error(E_SHORT, 1'b1);
                return;
            end
            hb = new[19];
            foreach (hdr_bytes[i])
                hb[i] = hdr_bytes[i];
            r.record_kind = K_HEAD;
            r.time_value = 48'(field_of(hb, 10, 4) | (field_of(hb, 14, 2) << 32));
            r.ident = 32'((field_of(hb, 0, 2) << 16) | field_of(hb, 2, 2));
            r.info = 56'((64'(hb[4]) << 48) | (64'(hb[5]) << 40) | (field_of(hb, 6, 2) << 24)
                     | (field_of(hb, 8, 2) << 8) | 64'(hb[16]));
            r.run_number = (need == 19) ? 16'(field_of(hb, 17, 2)) : 16'(hb[17]);
            expect_record(r);
            sh_phase = 1;
            sh_offset = 0;
            events_count = 0;
            hits_sum = 0;
            close_event(last);
            return;
        end
        if (sh_phase == 1)
        begin
            // A lone end marker at an event boundary closes newer packets cleanly.
            if (sh_offset == 0 && last && b == 8'hff && hdr_bytes[16] >= 4)
            begin
                push_accept();
                return;
            end
            evt_bytes[sh_offset] = b;
            sh_offset++;
            if (sh_offset < 12)
            begin
                if (last)
                    push_error(E_SHORT, 1'b1);
                return;
            end
            sh_offset = 0;
            n = evt_bytes[0];
            if (n > lim_hits)
            begin
                push_error(E_HITS, last);
                return;
            end
            hb = new[12];
            foreach (evt_bytes[i])
                hb[i] = evt_bytes[i];
            r.record_kind = K_EVT;
            r.time_value = 48'(field_of(hb, 6, 4) | (field_of(hb, 10, 2) << 32));
            r.ident = 32'(field_of(hb, 2, 4));
            r.info = 56'((n << 8) | hb[1]);
            expect_record(r);
            if (n == 0)
            begin
                events_count++;
                close_event(last);
                return;
            end
            hits_remaining = n;
            sh_phase = 2;
            if (last)
                push_error(E_SHORT, 1'b1);
            return;
        end
        // Hit words: the third byte completes one hit.
        if (sh_offset < 2)
        begin
            if (sh_offset == 0)
                hit_bytes[7:0] = b;
            else
                hit_bytes[15:8] = b;
            sh_offset++;
            if (last)
                push_error(E_SHORT, 1'b1);
            return;
        end
        h0 = hit_bytes[7:0];
        h1 = hit_bytes[15:8];
        r.record_kind = K_HIT;
        r.layer = hdr_bytes[4] + 8'd128;
        r.module_res = h0[7:5];
        r.row = h1[2:0];
        r.channel = h0[4:0];
        r.adc_value = {b[5:0], h1[7:3]};
        r.asic_code = b[7:6];
        expect_record(r);
        sh_offset = 0;
        hits_sum++;
        if (hits_remaining > 0)
            hits_remaining--;
        if (hits_remaining == 0)
        begin
            events_count++;
            sh_phase = 1;
            close_event(last);
            return;
        end
        if (last)
            push_error(E_SHORT, 1'b1);
    endfunction

    // Remember whether the offered byte was taken at the last rising edge.
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
    end

    // Input driver: offers the next queued byte, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
            begin
                // Hold the offered byte until it is taken.
            end
            else if (pending_bytes.size() > 0 && (calm_mode || $urandom_range(99) >= 32))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_bytes[0].data;
                s_tlast <= pending_bytes[0].last;
                void'(pending_bytes.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output ready: random stalls, or a long hold-off counted here.
    always @(negedge clk)
    begin
        if (stall_cycles > 0)
        begin
            m_tready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end
        else if (stall_hold)
        begin
            m_tready <= 1'b0;
            stall_cycles <= 300;
            stall_hold <= 1'b0;
        end
        else
            m_tready <= calm_mode || ($urandom_range(99) >= 32);
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge clk)
    begin
        rec_t got;
        rec_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[2:0], m_tdata[50:3], m_tdata[82:51], m_tdata[138:83],
                       m_tdata[154:139], m_tdata[162:155], m_tdata[165:163],
                       m_tdata[168:166], m_tdata[173:169], m_tdata[184:174],
                       m_tdata[186:185], m_tdata[188:187]};
                if (expected_records.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected record %h", got);
                end
                else
                begin
                    want = expected_records.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("record mismatch: expected %h actual %h", want, got);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EVENT_LIMIT)
            lim_events = val;
        else if (idx == CFG_HIT_LIMIT)
            lim_hits = val;
        else
            be_order = val[0];
    endtask

    // Wait until all bytes are sent and every record has arrived.
    task automatic drain();
        while (pending_bytes.size() > 0 || s_tvalid || expected_records.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic void add_byte(input logic [7:0] b, input bit last);
        byte_t t;
        t.data = b;
        t.last = last;
        pending_bytes.insert(pending_bytes.size(), t);
    endfunction

    // Queue one packet. cut is a byte count after which last is forced
    // (negative for none); trailer adds a lone 0xff end marker.
    task automatic queue_packet(input logic [7:0] version, input int n_events,
                                input int max_hits, input int cut, input bit trailer);
        logic [7:0] bytes_q[$];
        int n;
        for (int i = 0; i < 17; i++)
            bytes_q.insert(bytes_q.size(), 8'($urandom));
        bytes_q[16] = version;
        bytes_q.insert(bytes_q.size(), 8'($urandom));
        if (version >= 5)
            bytes_q.insert(bytes_q.size(), 8'($urandom));
        for (int e = 0; e < n_events; e++)
        begin
            n = $urandom_range(max_hits);
            bytes_q.insert(bytes_q.size(), 8'(n));
            for (int i = 1; i < 12; i++)
                bytes_q.insert(bytes_q.size(), 8'($urandom));
            for (int i = 0; i < 3 * n; i++)
                bytes_q.insert(bytes_q.size(), 8'($urandom));
        end
        if (trailer)
            bytes_q.insert(bytes_q.size(), 8'hff);
        if (cut >= 1 && cut < bytes_q.size())
            bytes_q = bytes_q[0:cut-1];
        foreach (bytes_q[i])
            add_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    initial
    begin
        int sent;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        mismatch_count = 0;
        calm_mode = 1'b0;
        stall_hold = 1'b0;
        stall_cycles = 0;
        lim_events = EventLimitReset;
        lim_hits = HitLimitReset;
        be_order = 1'b0;
        foreach (hdr_bytes[i])
            hdr_bytes[i] = '0;
        foreach (evt_bytes[i])
            evt_bytes[i] = '0;
        rearm();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: boundary ends, trailer, short packets and both limits.
        queue_packet(8'd5, 1, 2, -1, 1'b0);
        queue_packet(8'd3, 1, 1, -1, 1'b0);
        queue_packet(8'd4, 0, 0, -1, 1'b1);
        queue_packet(8'd2, 0, 0, -1, 1'b1);
        queue_packet(8'd255, 2, 3, 10, 1'b0);
        queue_packet(8'd6, 1, 3, 25, 1'b0);
        queue_packet(8'd0, 1, 4, 33, 1'b0);
        drain();
        write_reg(CFG_EVENT_LIMIT, 8'd0);
        write_reg(CFG_HIT_LIMIT, 8'd0);
        write_reg(CFG_BIG_ENDIAN, 8'd1);
        queue_packet(8'd5, 2, 0, -1, 1'b0);
        queue_packet(8'd5, 1, 8, -1, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h00, 1'b1);
        drain();
        write_reg(CFG_EVENT_LIMIT, 8'd255);
        write_reg(CFG_HIT_LIMIT, 8'd255);

        // Random part, with several register settings and a long output stall.
        sent = 0;
        for (int phase_i = 0; phase_i < 4; phase_i++)
        begin
            calm_mode = (phase_i == 2);
            if (phase_i == 1)
                stall_hold = 1'b1;
            while (sent < 240 * (phase_i + 1))
            begin
                int before_n;
                before_n = pending_bytes.size();
                if ($urandom_range(9) == 0)
                    add_byte(8'($urandom), $urandom_range(1));
                else
                    queue_packet(8'($urandom_range(7)), $urandom_range(3),
                                 $urandom_range(1) ? 4 : 24,
                                 $urandom_range(4) == 0 ? $urandom_range(40, 1) : -1,
                                 $urandom_range(3) == 0);
                sent += pending_bytes.size() - before_n;
            end
            drain();
            write_reg(CFG_EVENT_LIMIT, 8'($urandom_range(3)));
            write_reg(CFG_HIT_LIMIT, phase_i[0] ? 8'd3 : 8'($urandom));
            write_reg(CFG_BIG_ENDIAN, 8'($urandom_range(1)));
        end

        if (mismatch_count == 0 && expected_records.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
